/* design/hns_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hns_pkg: shared types and constants of the height map normal stream
// Holds the register layout, the controller state type and the command and
// status bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package hns_pkg;

   localparam int MAX_COLS_DEFAULT    = 1024;
   localparam int HEIGHT_BITS_DEFAULT = 16;
   localparam int MAX_ROWS            = 4096;

   localparam int COLS_REG_W = 11;
   localparam int ROWS_REG_W = 13;
   localparam int ROW_CNT_W  = 12;
   localparam int CSR_DATA_W = 13;

   localparam int QUOT_W   = 31;
   localparam int ROOT_W   = 16;
   localparam int STEP_W   = 5;
   localparam int NORM_W   = 16;
   localparam int NORM_Z_W = 15;

   localparam logic CSR_COLS = 1'b0;
   localparam logic CSR_ROWS = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SKIP,
      ST_RD_C,
      ST_RD_L,
      ST_RD_R,
      ST_GRAB,
      ST_DIFF,
      ST_MULT,
      ST_SUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_COMP_DONE,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      COMP_X,
      COMP_Y,
      COMP_Z
   } comp_type;

   typedef struct packed {
      logic     latch_h;
      logic     mem_we;
      logic     wr_sel;
      logic     done_sel;
      logic     cap_centre;
      logic     cap_left;
      logic     cap_right;
      logic     up_centre;
      logic     down_centre;
      logic     diff;
      logic     mult;
      logic     sum;
      logic     div_load;
      logic     div_step;
      logic     root_load;
      logic     root_step;
      logic     comp_store;
      comp_type comp;
      logic     out_load;
      logic     eof;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* design/heightmap_normal_stream.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// heightmap_normal_stream: height map to unit normal converter
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// Height samples enter in raster order and each grid point yields the unit
// normal of (left - right, previous row - next row, 2^(HEIGHT_BITS+1)) in
// Q1.14, one row late; flush beats drain the final row, and the last normal
// carries end_of_frame. A beat that produces a normal passes through three
// row-store reads, squaring, then per component a 31-step restoring divider
// and a 16-step square root that the three components share. A beat that
// produces nothing passes only through the skip state. The result register
// lets the next beat enter while a normal waits on rsp_stall. A write to
// either CSR restarts the frame.
module heightmap_normal_stream #(
   parameter int MAX_COLS    = hns_pkg::MAX_COLS_DEFAULT,
   parameter int HEIGHT_BITS = hns_pkg::HEIGHT_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_type,
   input  wire  [HEIGHT_BITS-1:0]              req_height,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [hns_pkg::NORM_W-1:0]   rsp_normal_x,
   output logic signed [hns_pkg::NORM_W-1:0]   rsp_normal_y,
   output logic [hns_pkg::NORM_Z_W-1:0]        rsp_normal_z,
   output logic                                rsp_end_of_frame,
   input  wire                                 csr_write_enable,
   input  wire                                 csr_index,
   input  wire  [hns_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hns_pkg::*;

   logic [$clog2(MAX_COLS)-1:0] addr;
   dp_cmd_type                  cmd;
   dp_status_type               status;

   hns_ctrl #(
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .addr             (addr),
      .cmd              (cmd),
      .status           (status)
   );

   hns_datapath #(
      .MAX_COLS    (MAX_COLS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_height       (req_height),
      .addr             (addr),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
`default_nettype wire

/* design/hns_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hns_ctrl: sequencer of the height map normal stream
// Keeps the frame counters and configuration, decides what each beat does
// and steps the datapath through reads, squaring, division and square root.
// ---------------------------------------------------------------------------
module hns_ctrl #(
   parameter int MAX_COLS = hns_pkg::MAX_COLS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_type,
   input  wire                            csr_write_enable,
   input  wire                            csr_index,
   input  wire  [hns_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [$clog2(MAX_COLS)-1:0]    addr,
   output hns_pkg::dp_cmd_type            cmd,
   input  hns_pkg::dp_status_type         status
);
   import hns_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int CMP_W  = (CNT_W > COLS_REG_W) ? CNT_W : COLS_REG_W;

   state_type             state_ff, state_in;
   logic [COLS_REG_W-1:0] cols_ff;
   logic [ROWS_REG_W-1:0] rows_ff;
   logic [ADDR_W-1:0]     col_ff;
   logic [ROW_CNT_W-1:0]  row_ff;
   logic                  sel_ff;
   logic                  drain_ff;
   logic [ADDR_W-1:0]     c_ff;
   logic                  item_drain_ff;
   logic                  item_write_ff;
   logic                  down_c_ff;
   comp_type              comp_ff;
   logic [STEP_W-1:0]     step_ff;

   logic [CMP_W-1:0]      cols_wide;
   logic [CNT_W-1:0]      cols_eff;
   logic [CNT_W-1:0]      cols_m1;
   logic [ROWS_REG_W-1:0] rows_eff;
   logic [ADDR_W-1:0]     c_now;
   logic                  c_last;
   logic                  accept;
   logic                  emit;
   logic                  upd;
   logic                  row_more;

   always_comb begin
      cols_wide = CMP_W'(cols_ff);
      if (cols_wide == '0) begin
         cols_eff = CNT_W'(1);
      end else if (cols_wide > CMP_W'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(cols_wide);
      end
      cols_m1 = cols_eff - CNT_W'(1);
      if (rows_ff == '0) begin
         rows_eff = ROWS_REG_W'(1);
      end else if (rows_ff > ROWS_REG_W'(MAX_ROWS)) begin
         rows_eff = ROWS_REG_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
      c_now    = ({1'b0, col_ff} >= cols_eff) ? cols_m1[ADDR_W-1:0] : col_ff;
      c_last   = ({1'b0, c_ff} + CNT_W'(1)) >= cols_eff;
      row_more = ({1'b0, row_ff} + ROWS_REG_W'(1)) < rows_eff;
      accept   = req_valid && (state_ff == ST_IDLE);
      emit     = drain_ff ? req_type : (!req_type && (row_ff != '0));
      upd      = ((state_ff == ST_FIN) && status.out_free) ||
                 ((state_ff == ST_SKIP) && item_write_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = emit ? ST_RD_C : ST_SKIP;
            end
         end
         ST_SKIP:      state_in = ST_IDLE;
         ST_RD_C:      state_in = ST_RD_L;
         ST_RD_L:      state_in = ST_RD_R;
         ST_RD_R:      state_in = ST_GRAB;
         ST_GRAB:      state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_MULT;
         ST_MULT:      state_in = ST_SUM;
         ST_SUM:       state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = ST_ROOT_LOAD;
            end
         end
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = ST_COMP_DONE;
            end
         end
         ST_COMP_DONE: state_in = (comp_ff == COMP_Z) ? ST_FIN : ST_DIV_LOAD;
         ST_FIN: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs to the datapath, and the request stall.
   always_comb begin
      cmd             = '0;
      cmd.done_sel    = ~sel_ff;
      cmd.wr_sel      = sel_ff;
      cmd.up_centre   = item_drain_ff;
      cmd.down_centre = down_c_ff;
      cmd.comp        = comp_ff;
      cmd.eof         = item_drain_ff && c_last;
      req_stall       = (state_ff != ST_IDLE);
      addr            = c_ff;
      case (state_ff)
         ST_IDLE:      cmd.latch_h = accept;
         ST_SKIP:      cmd.mem_we = item_write_ff;
         ST_RD_C:      addr = c_ff;
         ST_RD_L: begin
            addr           = (c_ff == '0) ? c_ff : c_ff - ADDR_W'(1);
            cmd.cap_centre = 1'b1;
         end
         ST_RD_R: begin
            addr         = c_last ? c_ff : c_ff + ADDR_W'(1);
            cmd.cap_left = 1'b1;
         end
         ST_GRAB:      cmd.cap_right = 1'b1;
         ST_DIFF:      cmd.diff = 1'b1;
         ST_MULT:      cmd.mult = 1'b1;
         ST_SUM:       cmd.sum = 1'b1;
         ST_DIV_LOAD:  cmd.div_load = 1'b1;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_COMP_DONE: cmd.comp_store = 1'b1;
         ST_FIN: begin
            cmd.out_load = status.out_free;
            cmd.mem_we   = status.out_free && !item_drain_ff;
         end
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cols_ff  <= COLS_REG_W'(1024);
         rows_ff  <= ROWS_REG_W'(1024);
         col_ff   <= '0;
         row_ff   <= '0;
         sel_ff   <= 1'b0;
         drain_ff <= 1'b0;
         comp_ff  <= COMP_X;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_COLS) begin
               cols_ff <= csr_data[COLS_REG_W-1:0];
            end else begin
               rows_ff <= csr_data;
            end
            col_ff   <= '0;
            row_ff   <= '0;
            sel_ff   <= 1'b0;
            drain_ff <= 1'b0;
         end else if (upd) begin
            if (item_drain_ff) begin
               if (c_last) begin
                  col_ff   <= '0;
                  row_ff   <= '0;
                  sel_ff   <= 1'b0;
                  drain_ff <= 1'b0;
               end else begin
                  col_ff <= c_ff + ADDR_W'(1);
               end
            end else if (!c_last) begin
               col_ff <= c_ff + ADDR_W'(1);
            end else begin
               col_ff <= '0;
               sel_ff <= ~sel_ff;
               if (row_more) begin
                  row_ff <= row_ff + ROW_CNT_W'(1);
               end else begin
                  drain_ff <= 1'b1;
               end
            end
         end
         if (state_ff == ST_SUM) begin
            comp_ff <= COMP_X;
         end else if (state_ff == ST_COMP_DONE) begin
            case (comp_ff)
               COMP_X:  comp_ff <= COMP_Y;
               COMP_Y:  comp_ff <= COMP_Z;
               default: comp_ff <= COMP_Z;
            endcase
         end
         if ((state_ff == ST_DIV_LOAD) || (state_ff == ST_ROOT_LOAD)) begin
            step_ff <= '0;
         end else if ((state_ff == ST_DIV) || (state_ff == ST_ROOT)) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // Beat context, captured when a beat is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff          <= c_now;
         item_drain_ff <= drain_ff;
         item_write_ff <= !drain_ff && !req_type;
         down_c_ff     <= drain_ff ? (rows_eff < ROWS_REG_W'(2)) :
                                     (row_ff < ROW_CNT_W'(2));
      end
   end

endmodule
`default_nettype wire

/* design/hns_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hns_datapath: row stores and normalizer of the height map normal stream
// Two row memories, the neighbor registers, the squarers, a shared
// restoring divider and a shared bit-serial square root, and the result
// register.
// ---------------------------------------------------------------------------
module hns_datapath #(
   parameter int MAX_COLS    = hns_pkg::MAX_COLS_DEFAULT,
   parameter int HEIGHT_BITS = hns_pkg::HEIGHT_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [HEIGHT_BITS-1:0]              req_height,
   input  wire  [$clog2(MAX_COLS)-1:0]         addr,
   input  hns_pkg::dp_cmd_type                 cmd,
   output hns_pkg::dp_status_type              status,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [hns_pkg::NORM_W-1:0]   rsp_normal_x,
   output logic signed [hns_pkg::NORM_W-1:0]   rsp_normal_y,
   output logic [hns_pkg::NORM_Z_W-1:0]        rsp_normal_z,
   output logic                                rsp_end_of_frame
);
   import hns_pkg::*;

   localparam int H   = HEIGHT_BITS;
   localparam int S_W = 2 * H + 3;
   localparam logic [S_W-1:0] Z2 = S_W'(1) << (2 * H + 2);

   logic [H-1:0]       mem_a_ff [MAX_COLS];
   logic [H-1:0]       mem_b_ff [MAX_COLS];
   logic [H-1:0]       rd_a_ff, rd_b_ff;
   logic [H-1:0]       h_ff, centre_ff, down_ff, left_ff, right_ff;
   logic [H-1:0]       ax_ff, ay_ff;
   logic               neg_x_ff, neg_y_ff;
   logic [2*H-1:0]     a2x_ff, a2y_ff;
   logic [S_W-1:0]     s_ff;
   logic [S_W:0]       rem_ff;
   logic               nbit_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [ROOT_W-1:0]  root_ff, mask_ff;
   logic [NORM_W-1:0]  nx_ff, ny_ff;
   logic [NORM_Z_W-1:0] nz_ff;
   logic               rsp_valid_ff;

   logic [H-1:0]       done_rd, other_rd, up_val, down_val;
   logic [H:0]         dx, dy, mx, my;
   logic [S_W-1:0]     a2_sel;
   logic [S_W:0]       trial;
   logic [ROOT_W-1:0]  cand;
   logic [2*ROOT_W-1:0] cand_sq;
   logic [ROOT_W:0]    m_sum;
   logic [NORM_W-1:0]  m_val;

   always_comb begin
      done_rd  = cmd.done_sel ? rd_b_ff : rd_a_ff;
      other_rd = cmd.done_sel ? rd_a_ff : rd_b_ff;
      up_val   = cmd.up_centre ? centre_ff : h_ff;
      down_val = cmd.down_centre ? centre_ff : down_ff;
      dx       = {1'b0, left_ff} - {1'b0, right_ff};
      dy       = {1'b0, down_val} - {1'b0, up_val};
      mx       = dx[H] ? (~dx + (H+1)'(1)) : dx;
      my       = dy[H] ? (~dy + (H+1)'(1)) : dy;
      case (cmd.comp)
         COMP_X:  a2_sel = S_W'(a2x_ff);
         COMP_Y:  a2_sel = S_W'(a2y_ff);
         default: a2_sel = Z2;
      endcase
      trial   = {rem_ff[S_W-1:0], nbit_ff};
      cand    = root_ff | mask_ff;
      cand_sq = cand * cand;
      // Rounding to nearest: the largest odd d with d*d <= q is root or root-1.
      m_sum   = {1'b0, root_ff} + (ROOT_W+1)'(1);
      m_val   = m_sum[ROOT_W:1];
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_a_ff[addr];
      rd_b_ff <= mem_b_ff[addr];
      if (cmd.mem_we && !cmd.wr_sel) begin
         mem_a_ff[addr] <= h_ff;
      end
      if (cmd.mem_we && cmd.wr_sel) begin
         mem_b_ff[addr] <= h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_h) begin
         h_ff <= req_height;
      end
      if (cmd.cap_centre) begin
         centre_ff <= done_rd;
         down_ff   <= other_rd;
      end
      if (cmd.cap_left) begin
         left_ff <= done_rd;
      end
      if (cmd.cap_right) begin
         right_ff <= done_rd;
      end
      if (cmd.diff) begin
         ax_ff    <= mx[H-1:0];
         ay_ff    <= my[H-1:0];
         neg_x_ff <= dx[H];
         neg_y_ff <= dy[H];
      end
      if (cmd.mult) begin
         a2x_ff <= ax_ff * ax_ff;
         a2y_ff <= ay_ff * ay_ff;
      end
      if (cmd.sum) begin
         s_ff <= S_W'(a2x_ff) + S_W'(a2y_ff) + Z2;
      end
      // The quotient is floor(a*a*2^30 / s); the dividend starts at a*a/2
      // so that the first partial remainder is already below the divisor.
      if (cmd.div_load) begin
         rem_ff  <= (S_W+1)'(a2_sel >> 1);
         nbit_ff <= a2_sel[0];
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         nbit_ff <= 1'b0;
         if (trial >= {1'b0, s_ff}) begin
            rem_ff  <= trial - {1'b0, s_ff};
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= trial;
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end
      if (cmd.root_load) begin
         root_ff <= '0;
         mask_ff <= {1'b1, {(ROOT_W-1){1'b0}}};
      end else if (cmd.root_step) begin
         if (cand_sq <= {1'b0, quot_ff}) begin
            root_ff <= cand;
         end
         mask_ff <= mask_ff >> 1;
      end
      if (cmd.comp_store) begin
         case (cmd.comp)
            COMP_X:  nx_ff <= neg_x_ff ? (~m_val + NORM_W'(1)) : m_val;
            COMP_Y:  ny_ff <= neg_y_ff ? (~m_val + NORM_W'(1)) : m_val;
            default: nz_ff <= m_val[NORM_Z_W-1:0];
         endcase
      end
      if (cmd.out_load) begin
         rsp_normal_x     <= nx_ff;
         rsp_normal_y     <= ny_ff;
         rsp_normal_z     <= nz_ff;
         rsp_end_of_frame <= cmd.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* design/hns_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// hns_checker: port checks of the height map normal stream
// Watches the top-level ports and flags broken beats and impossible normals.
// ---------------------------------------------------------------------------
module hns_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire signed [hns_pkg::NORM_W-1:0]   rsp_normal_x,
   input wire signed [hns_pkg::NORM_W-1:0]   rsp_normal_y,
   input wire [hns_pkg::NORM_Z_W-1:0]        rsp_normal_z,
   input wire                                rsp_end_of_frame
);
   import hns_pkg::*;

   // A stalled result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x) &&
      $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_end_of_frame))
      else $error("stalled result beat changed");

   // A taken beat raises req_stall, so no two beats are taken back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back-to-back cycles");

   // The z component of a unit normal with z = 2^(HEIGHT_BITS+1) can never round to zero.
   a_z_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_z != '0)
      else $error("normal z component is zero");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x >= -16'sd16384) && (rsp_normal_x <= 16'sd16384) &&
                    (rsp_normal_y >= -16'sd16384) && (rsp_normal_y <= 16'sd16384))
      else $error("normal component out of unit range");

endmodule

bind heightmap_normal_stream hns_checker u_hns_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_normal_x     (rsp_normal_x),
   .rsp_normal_y     (rsp_normal_y),
   .rsp_normal_z     (rsp_normal_z),
   .rsp_end_of_frame (rsp_end_of_frame)
);
`default_nettype wire
